/* sv/calendar_date_shifter_defines.svh */
// ----------------------------------------------------------------------------
// Calendar date shifter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_SHIFTER_DEFINES_SVH
`define CALENDAR_DATE_SHIFTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CDS_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define CDS_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) else $error(msg);

`endif

/* sv/cds_pkg.sv */
// ----------------------------------------------------------------------------
// Calendar date shifter package
// Word types, operation and status codes, and calendar constants.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned AluW  = 19;
  localparam int unsigned DayW  = 17;

  localparam logic [YearW-1:0] YearMax   = 14'd9999;
  localparam logic signed [AluW-1:0] TotMonthMax = 19'sd119999;
  localparam logic signed [AluW-1:0] TotYearMax  = 19'sd9999;

  // floor(y / 100) = (y * Recip100) >> 19 for every 14-bit y.
  localparam logic [12:0] Recip100 = 13'd5243;
  // floor(t / 3) = (t * Recip3) >> 17 for every 16-bit t.
  localparam logic [15:0] Recip3   = 16'd43691;
  localparam logic [14:0] Hundred  = 15'd100;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_DAYS   = 2'd1,
    FN_MONTHS = 2'd2,
    FN_YEARS  = 2'd3
  } cds_func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_RANGE    = 2'd2
  } cds_status_e;

  typedef struct packed {
    cds_func_e          func;
    logic signed [15:0] amount;
    logic [13:0]        load_year;
    logic [3:0]         load_month;
    logic [4:0]         load_day;
  } cds_in_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    cds_status_e status;
  } cds_out_t;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of a month; codes outside 1 to 12 read as 31 and are screened
  // out separately by the load check.
  function automatic logic [4:0] days_in_month(logic [3:0] month, logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (month >= 4'd1 && month <= 4'd12) begin
      len = MonthLen[month - 4'd1];
    end
    if (month == 4'd2 && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

/* sv/cds_alu.sv */
// ----------------------------------------------------------------------------
// Calendar date shifter adder
// Shared signed add/subtract unit with a positive-result flag.
// ----------------------------------------------------------------------------
module cds_alu (
  input  logic signed [cds_pkg::AluW-1:0] a_i,
  input  logic signed [cds_pkg::AluW-1:0] b_i,
  input  logic                            sub_i,
  output logic signed [cds_pkg::AluW-1:0] sum_o,
  output logic                            pos_o
);

  always_comb begin
    sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
    pos_o = !sum_o[cds_pkg::AluW-1] && (sum_o != '0);
  end

endmodule

/* sv/cds_leap.sv */
// ----------------------------------------------------------------------------
// Calendar date shifter leap-year unit
// Two-stage pipeline: divide by 100 through a reciprocal, then test.
// ----------------------------------------------------------------------------
module cds_leap (
  input  logic                         clk_i,
  input  logic [cds_pkg::YearW-1:0]    year_i,
  output logic                         leap_o
);

  logic [26:0]               prod;
  logic [7:0]                cent_d, cent_q;
  logic [cds_pkg::YearW-1:0] year_q;
  logic [14:0]               cent_x100;
  logic                      leap_d, leap_q;

  always_comb begin
    prod      = 27'(year_i) * 27'(cds_pkg::Recip100);
    cent_d    = prod[26:19];
    cent_x100 = 15'(cent_q) * cds_pkg::Hundred;
    // Divisible by 4, and either not a century or a century divisible by 4.
    leap_d    = (year_q[1:0] == 2'b00) &&
                ((15'(year_q) != cent_x100) || (cent_q[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    cent_q <= cent_d;
    year_q <= year_i;
    leap_q <= leap_d;
  end

  assign leap_o = leap_q;

endmodule

/* sv/calendar_date_shifter.sv */
// ----------------------------------------------------------------------------
// Calendar date shifter
// Holds a Gregorian date and loads it or shifts it by days, months or years.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+-----------------------
//  in      | input     | in_valid_i/in_ready_o  | cds_pkg::cds_in_t
//  out     | output    | out_valid_o/out_ready_i| cds_pkg::cds_out_t
//
// One word is taken at a time; in_ready_o is high only while the sequencer
// is idle. A load waits in S_LP0 and S_LP1 for the leap-year unit before
// its check, and an in-range month or year shift before its clamp. A day
// shift waits there first, then walks the date one month per cycle through
// the shared adder, waiting in S_LP0 and S_LP1 again each time a year is
// crossed. Reset loads 1 January 2000 and clears the handshake.
// A stalled result sits in the output register; the next word may already be
// accepted and worked on, and it waits in the final state for a free slot.
//
`include "calendar_date_shifter_defines.svh"

module calendar_date_shifter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cds_pkg::cds_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cds_pkg::cds_out_t out_data_o
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_RCHK  = 4'd2;
  localparam logic [3:0] S_MDIV  = 4'd3;
  localparam logic [3:0] S_LP0   = 4'd4;
  localparam logic [3:0] S_LP1   = 4'd5;
  localparam logic [3:0] S_LCHK  = 4'd6;
  localparam logic [3:0] S_DAY   = 4'd7;
  localparam logic [3:0] S_CLAMP = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int unsigned YW = cds_pkg::YearW;
  localparam int unsigned AW = cds_pkg::AluW;
  localparam int unsigned DW = cds_pkg::DayW;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;

  // Held date.
  logic [YW-1:0] cur_y_q, cur_y_d;
  logic [3:0]    cur_m_q, cur_m_d;
  logic [4:0]    cur_d_q, cur_d_d;

  // Working registers.
  cds_pkg::cds_func_e    fn_q, fn_d;
  logic signed [15:0]    amt_q, amt_d;
  logic [YW-1:0]         wy_q, wy_d;
  logic [3:0]            wm_q, wm_d;
  logic signed [DW-1:0]  wd_q, wd_d;
  logic signed [AW-1:0]  tot_q, tot_d;
  logic [31:0]           prod_q, prod_d;
  cds_pkg::cds_status_e  status_q, status_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  cds_pkg::cds_out_t out_q, out_d;
  logic              out_load;

  // Shared adder.
  logic signed [AW-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_pos;

  logic       leap;
  logic [4:0] cur_dim, prev_dim;
  logic [3:0] prev_m;
  logic       back;
  logic [18:0] y_months;
  logic [14:0] quot;
  logic [17:0] quot18, rem18;
  logic        accept;

  cds_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .pos_o (alu_pos)
  );

  // The leap unit follows the working year; its answer passes through the
  // unit's divide and test registers after that year settles.
  cds_leap u_leap (
    .clk_i  (clk_i),
    .year_i (wy_q),
    .leap_o (leap)
  );

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cur_dim  = cds_pkg::days_in_month(wm_q, leap);
    // Stepping back from January lands in December, which is 31 days in
    // any year, so the current leap flag serves.
    prev_m   = (wm_q == 4'd1) ? 4'd12 : (wm_q - 4'd1);
    prev_dim = cds_pkg::days_in_month(prev_m, leap);
    back     = wd_q[DW-1] || (wd_q == '0);
    y_months = ({5'b0, cur_y_q} << 3) + ({5'b0, cur_y_q} << 2) +
               {15'b0, cur_m_q} - 19'd1;
    quot     = prod_q[31:17];
    quot18   = {3'b0, quot};
    rem18    = tot_q[17:0] - (quot18 << 3) - (quot18 << 2);
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_PREP: begin
        alu_b = AW'(amt_q);
        case (fn_q)
          cds_pkg::FN_DAYS:   alu_a = signed'({14'b0, cur_d_q});
          cds_pkg::FN_MONTHS: alu_a = signed'(y_months);
          default:            alu_a = signed'({5'b0, cur_y_q});
        endcase
      end
      S_DAY: begin
        alu_a   = AW'(wd_q);
        alu_b   = back ? signed'({14'b0, prev_dim}) : signed'({14'b0, cur_dim});
        alu_sub = !back;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cur_y_d  = cur_y_q;
    cur_m_d  = cur_m_q;
    cur_d_d  = cur_d_q;
    fn_d     = fn_q;
    amt_d    = amt_q;
    wy_d     = wy_q;
    wm_d     = wm_q;
    wd_d     = wd_q;
    tot_d    = tot_q;
    prod_d   = prod_q;
    status_d = status_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          fn_d     = in_data_i.func;
          amt_d    = in_data_i.amount;
          status_d = cds_pkg::ST_OK;
          if (in_data_i.func == cds_pkg::FN_LOAD) begin
            wy_d = in_data_i.load_year;
            wm_d = in_data_i.load_month;
            wd_d = signed'({12'b0, in_data_i.load_day});
          end else begin
            wy_d = cur_y_q;
            wm_d = cur_m_q;
            wd_d = signed'({12'b0, cur_d_q});
          end
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        case (fn_q)
          cds_pkg::FN_LOAD: begin
            ret_d   = S_LCHK;
            state_d = S_LP0;
          end
          cds_pkg::FN_DAYS: begin
            wd_d    = alu_sum[DW-1:0];
            ret_d   = S_DAY;
            state_d = S_LP0;
          end
          default: begin
            tot_d   = alu_sum;
            state_d = S_RCHK;
          end
        endcase
      end
      S_RCHK: begin
        if (fn_q == cds_pkg::FN_MONTHS) begin
          if (tot_q[AW-1] || (tot_q > cds_pkg::TotMonthMax)) begin
            status_d = cds_pkg::ST_RANGE;
            state_d  = S_DONE;
          end else begin
            prod_d  = {16'b0, tot_q[17:2]} * {16'b0, cds_pkg::Recip3};
            state_d = S_MDIV;
          end
        end else begin
          if (tot_q[AW-1] || (tot_q > cds_pkg::TotYearMax)) begin
            status_d = cds_pkg::ST_RANGE;
            state_d  = S_DONE;
          end else begin
            wy_d    = tot_q[YW-1:0];
            ret_d   = S_CLAMP;
            state_d = S_LP0;
          end
        end
      end
      S_MDIV: begin
        // Quotient by 12 is the year, remainder the zero-based month.
        wy_d    = quot[YW-1:0];
        wm_d    = rem18[3:0] + 4'd1;
        ret_d   = S_CLAMP;
        state_d = S_LP0;
      end
      S_LP0: begin
        state_d = S_LP1;
      end
      S_LP1: begin
        state_d = ret_q;
      end
      S_LCHK: begin
        if ((wy_q <= cds_pkg::YearMax) && (wm_q != 4'd0) && (wm_q <= 4'd12) &&
            (wd_q[4:0] != 5'd0) && (wd_q[4:0] <= cur_dim)) begin
          cur_y_d = wy_q;
          cur_m_d = wm_q;
          cur_d_d = wd_q[4:0];
        end else begin
          status_d = cds_pkg::ST_BAD_LOAD;
        end
        state_d = S_DONE;
      end
      S_DAY: begin
        if (back) begin
          // Borrow the previous month's length.
          if (wm_q == 4'd1) begin
            if (wy_q == '0) begin
              status_d = cds_pkg::ST_RANGE;
              state_d  = S_DONE;
            end else begin
              wy_d    = wy_q - YW'(1);
              wm_d    = 4'd12;
              wd_d    = alu_sum[DW-1:0];
              ret_d   = S_DAY;
              state_d = S_LP0;
            end
          end else begin
            wm_d = prev_m;
            wd_d = alu_sum[DW-1:0];
          end
        end else if (alu_pos) begin
          // Day past the end of the month: carry into the next one.
          wd_d = alu_sum[DW-1:0];
          if (wm_q == 4'd12) begin
            if (wy_q == cds_pkg::YearMax) begin
              status_d = cds_pkg::ST_RANGE;
              state_d  = S_DONE;
            end else begin
              wy_d    = wy_q + YW'(1);
              wm_d    = 4'd1;
              ret_d   = S_DAY;
              state_d = S_LP0;
            end
          end else begin
            wm_d = wm_q + 4'd1;
          end
        end else begin
          cur_y_d = wy_q;
          cur_m_d = wm_q;
          cur_d_d = wd_q[4:0];
          state_d = S_DONE;
        end
      end
      S_CLAMP: begin
        cur_y_d = wy_q;
        cur_m_d = wm_q;
        cur_d_d = (cur_d_q > cur_dim) ? cur_dim : cur_d_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The result goes out once the output register is free.
  always_comb begin
    out_load          = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
    out_d             = out_q;
    out_d.out_year    = cur_y_q;
    out_d.out_month   = cur_m_q;
    out_d.out_day     = cur_d_q;
    out_d.status      = status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cur_y_q     <= 14'd2000;
      cur_m_q     <= 4'd1;
      cur_d_q     <= 5'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cur_y_q     <= cur_y_d;
      cur_m_q     <= cur_m_d;
      cur_d_q     <= cur_d_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q     <= fn_d;
    amt_q    <= amt_d;
    wy_q     <= wy_d;
    wm_q     <= wm_d;
    wd_q     <= wd_d;
    tot_q    <= tot_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The held date always has a month from 1 to 12, a day of at least 1 and a year within the range.
  `CDS_ASSERT_ALWAYS(a_held_date_valid, (cur_m_q >= 4'd1) && (cur_m_q <= 4'd12) && (cur_d_q >= 5'd1) && (cur_y_q <= cds_pkg::YearMax), "held date is not a valid date")
  // An accepted word always starts the sequencer.
  `CDS_ASSERT_NEXT(a_accept_starts, accept, state_q == S_PREP, "accepted word did not start work")
  // A finished word with a free output slot is shown on the next cycle.
  `CDS_ASSERT_NEXT(a_done_delivers, out_load, out_valid_o && (state_q == S_IDLE), "finished word not delivered")
  // The day walk keeps its month and year in range.
  `CDS_ASSERT_ALWAYS(a_day_walk_range, (state_q != S_DAY) || ((wm_q >= 4'd1) && (wm_q <= 4'd12) && (wy_q <= cds_pkg::YearMax)), "day walk left the calendar")

endmodule

/* verif/calendar_date_shifter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date shifter testbench
// Drives load and day, month and year shift words through the block and
// compares every result word with an in-bench Gregorian calendar model.
// ----------------------------------------------------------------------------
module calendar_date_shifter_tb;

  localparam int LastYear    = 9999;
  localparam int DrainCycles = 40;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  cds_pkg::cds_in_t  in_word;
  logic              out_valid;
  logic              out_ready;
  cds_pkg::cds_out_t out_word;

  // Calendar model state: the date the block should be holding.
  int held_year;
  int held_month;
  int held_day;

  cds_pkg::cds_out_t expected_dates [$];
  cds_pkg::cds_out_t oldest_date;
  int                error_count    = 0;
  int                results_seen   = 0;
  int                rejected_count = 0;
  int                func_count [4];
  bit                no_idle;

  calendar_date_shifter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver back-pressure, switched off during the quiet stretch.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 19);
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int y, int m);
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return MonthDays[m - 1];
  endfunction

  // Applies one word to the held date and returns the result word it causes.
  function automatic cds_pkg::cds_out_t step_date(cds_pkg::cds_in_t w);
    int                   y;
    int                   m;
    int                   d;
    int                   amt;
    int                   total;
    cds_pkg::cds_status_e st;
    cds_pkg::cds_out_t    r;
    y   = held_year;
    m   = held_month;
    d   = held_day;
    amt = int'($signed(w.amount));
    st  = cds_pkg::ST_OK;
    case (w.func)
      cds_pkg::FN_LOAD: begin
        if (w.load_year > LastYear || w.load_month < 1 || w.load_month > 12 ||
            w.load_day < 1) begin
          st = cds_pkg::ST_BAD_LOAD;
        end else if (w.load_day > month_length(int'(w.load_year), int'(w.load_month))) begin
          st = cds_pkg::ST_BAD_LOAD;
        end else begin
          y = w.load_year;
          m = w.load_month;
          d = w.load_day;
        end
      end
      cds_pkg::FN_DAYS: begin
        // Walk month by month; leaving the year range stops the walk.
        d = d + amt;
        while (st == cds_pkg::ST_OK && d > month_length(y, m)) begin
          d = d - month_length(y, m);
          m++;
          if (m > 12) begin
            m = 1;
            y++;
            if (y > LastYear) st = cds_pkg::ST_RANGE;
          end
        end
        while (st == cds_pkg::ST_OK && d < 1) begin
          m--;
          if (m < 1) begin
            m = 12;
            y--;
            if (y < 0) st = cds_pkg::ST_RANGE;
          end
          if (st == cds_pkg::ST_OK) d = d + month_length(y, m);
        end
      end
      cds_pkg::FN_MONTHS: begin
        total = y * 12 + (m - 1) + amt;
        if (total < 0 || total > LastYear * 12 + 11) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          y = total / 12;
          m = total % 12 + 1;
          if (d > month_length(y, m)) d = month_length(y, m);
        end
      end
      default: begin
        if (y + amt < 0 || y + amt > LastYear) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          y = y + amt;
          if (d > month_length(y, m)) d = month_length(y, m);
        end
      end
    endcase
    if (st == cds_pkg::ST_OK) begin
      held_year  = y;
      held_month = m;
      held_day   = d;
    end
    r.out_year  = 14'(held_year);
    r.out_month = 4'(held_month);
    r.out_day   = 5'(held_day);
    r.status    = st;
    return r;
  endfunction

  function automatic cds_pkg::cds_in_t make_word(cds_pkg::cds_func_e f, int amt, int y,
                                                 int m, int d);
    cds_pkg::cds_in_t w;
    w.func       = f;
    w.amount     = 16'(amt);
    w.load_year  = 14'(y);
    w.load_month = 4'(m);
    w.load_day   = 5'(d);
    return w;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Sends one word. Entered and left at a falling edge; valid stays high on
  // exit so that a word sent straight after needs no second assignment.
  task automatic send_word(cds_pkg::cds_in_t w);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_dates.push_back(step_date(w));
    func_count[int'(w.func)]++;
    @(negedge clk);
  endtask

  // Every result word is matched against the oldest expected date.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result word with nothing expected: %0d-%0d-%0d status %0d",
               out_word.out_year, out_word.out_month, out_word.out_day,
               out_word.status);
        error_count++;
      end else begin
        oldest_date = expected_dates.pop_front();
        check_field("out_year", oldest_date.out_year, out_word.out_year);
        check_field("out_month", oldest_date.out_month, out_word.out_month);
        check_field("out_day", oldest_date.out_day, out_word.out_day);
        check_field("status", int'(oldest_date.status), int'(out_word.status));
        if (oldest_date.status != cds_pkg::ST_OK) rejected_count++;
        results_seen++;
      end
    end
  end

  // Zero shifts right after reset must report the reset date untouched.
  task automatic test_reset_date();
    send_word(make_word(cds_pkg::FN_DAYS, 0, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_YEARS, 0, 0, 0, 0));
  endtask

  task automatic test_load_checks();
    send_word(make_word(cds_pkg::FN_LOAD, 0, 9999, 12, 31));
    send_word(make_word(cds_pkg::FN_LOAD, -1, 16383, 1, 1));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2024, 0, 1));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2024, 15, 1));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2024, 4, 0));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2024, 4, 31));
    // Century years are not leap years unless divisible by 400.
    send_word(make_word(cds_pkg::FN_LOAD, 0, 1900, 2, 29));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2000, 2, 29));
    // Year zero is divisible by 400 and so is a leap year.
    send_word(make_word(cds_pkg::FN_LOAD, 0, 0, 2, 29));
  endtask

  task automatic test_range_limits();
    send_word(make_word(cds_pkg::FN_LOAD, 0, 0, 1, 1));
    send_word(make_word(cds_pkg::FN_DAYS, -1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_MONTHS, -1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_YEARS, -1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_DAYS, 32767, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 9999, 12, 31));
    send_word(make_word(cds_pkg::FN_DAYS, 1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_MONTHS, 1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_YEARS, 1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_DAYS, -32768, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_MONTHS, -32768, 0, 0, 0));
  endtask

  task automatic test_month_end_clamping();
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2000, 2, 29));
    send_word(make_word(cds_pkg::FN_YEARS, 1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2023, 1, 31));
    send_word(make_word(cds_pkg::FN_MONTHS, 1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_LOAD, 0, 2024, 3, 31));
    send_word(make_word(cds_pkg::FN_MONTHS, -1, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_YEARS, -32768, 0, 0, 0));
    send_word(make_word(cds_pkg::FN_MONTHS, 32767, 0, 0, 0));
  endtask

  // Mostly well-formed loads and modest shifts, so the date wanders through
  // many months and years; a few full-range amounts and junk loads mixed in.
  task automatic test_random_traffic(int count, bit quiet);
    cds_pkg::cds_func_e f;
    int                 pick;
    int                 amt;
    int                 y;
    int                 m;
    int                 d;
    no_idle = quiet;
    repeat (count) begin
      f    = cds_pkg::cds_func_e'($urandom_range(3));
      pick = $urandom_range(99);
      y    = $urandom_range(16383);
      m    = $urandom_range(15);
      d    = $urandom_range(31);
      if (f == cds_pkg::FN_LOAD && pick < 75) begin
        if (pick < 8) y = $urandom_range(3);
        else if (pick < 15) y = 9996 + $urandom_range(3);
        else y = $urandom_range(9999);
        m = $urandom_range(12, 1);
        d = $urandom_range(month_length(y, m), 1);
      end
      pick = $urandom_range(99);
      if (pick < 5) amt = 0;
      else if (pick < 60) amt = int'($urandom_range(80)) - 40;
      else if (pick < 88) amt = int'($urandom_range(1600)) - 800;
      else amt = int'($urandom_range(65535)) - 32768;
      send_word(make_word(f, amt, y, m, d));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    no_idle        = 1'b0;
    func_count     = '{0, 0, 0, 0};
    held_year      = 2000;
    held_month     = 1;
    held_day       = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_date();
    test_load_checks();
    test_range_limits();
    test_month_end_clamping();
    test_random_traffic(175, 1'b0);
    test_random_traffic(100, 1'b1);
    test_random_traffic(175, 1'b0);

    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d loads and %0d day, %0d month, %0d year shifts.",
             func_count[int'(cds_pkg::FN_LOAD)], func_count[int'(cds_pkg::FN_DAYS)],
             func_count[int'(cds_pkg::FN_MONTHS)], func_count[int'(cds_pkg::FN_YEARS)]);
    $display("Checked %0d result words, %0d of them rejections.",
             results_seen, rejected_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Long day shifts walk the date one month at a time; this bound is a
  // watchdog on the whole run and lies far beyond its expected length.
  initial begin
    #25_000_000;
    $display("Timed out waiting for the block.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
